@@ hdl/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define FBDR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define FBDR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/fbdr_pkg.sv @@
package fbdr_pkg;

  localparam int ROWS_DEFAULT    = 32;
  localparam int COLUMNS_DEFAULT = 16;

  // Field widths fixed by the interface.
  localparam int ROW_W  = 5;
  localparam int COL_W  = 4;
  localparam int WORD_W = 16;
  localparam int BYTE_W = 8;

  // Wide enough for row * COLUMNS + column at the largest column count.
  localparam int FULL_ADDR_W = 11;

  localparam logic [BYTE_W-1:0] ADDR_CMD = 8'h80;

  // Which byte of a request the emitter is sending.
  typedef enum logic [1:0] {
    BYTE_ROW = 2'd0,
    BYTE_COL = 2'd1,
    BYTE_HI  = 2'd2,
    BYTE_LO  = 2'd3
  } byte_sel_t;

  // One changed word, handed from the update stage to the emitter.
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [WORD_W-1:0] word;
    logic              cont;
  } rec_t;

endpackage

@@ hdl/framebuffer_diff_refresh.sv @@
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    row_index, column_index, pixel_word
// out_      output     out_valid/out_ready  is_data, out_byte, last_of_run
// cfg_      input      cfg_valid/cfg_ready  drawing_enabled
//
// A changed word produces four bytes, or two when it continues an open run, at one
// byte per cycle while out_ready holds; the byte-wide result register sets that
// rate. Unchanged or ignored words produce no bytes and do not wait on the output.
// After reset the shadow memory is swept to zero, all ROWS * COLUMNS entries
// (512 by default), during which in_ready stays low; cfg writes are taken anyway.
// A stalled output holds the update stage but never loses a byte.

module framebuffer_diff_refresh #(
  parameter int ROWS    = fbdr_pkg::ROWS_DEFAULT,
  parameter int COLUMNS = fbdr_pkg::COLUMNS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fbdr_pkg::ROW_W-1:0]  in_row_index,
  input  logic [fbdr_pkg::COL_W-1:0]  in_column_index,
  input  logic [fbdr_pkg::WORD_W-1:0] in_pixel_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_is_data,
  output logic [fbdr_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last_of_run,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_drawing_enabled
);

  // One shadow entry per 16-pixel word of the panel.
  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic drawing_enabled_r;

  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [fbdr_pkg::WORD_W-1:0] rd_data;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [fbdr_pkg::WORD_W-1:0] wr_data;
  logic                        clr_busy;

  logic           rec_push;
  fbdr_pkg::rec_t rec_data;
  logic           rec_ready;

  // The single configuration register can be written at any time; it is
  // sampled with each request as that request enters the update stage.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drawing_enabled_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      drawing_enabled_r <= cfg_drawing_enabled;
    end
  end

  // Shadow copy of the panel contents; its read data is registered ahead of the compare.
  fbdr_shadow_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .clr_busy (clr_busy)
  );

  // Compare against the shadow, write back changed words and track the open
  // run. A write that lands on the edge of the next read is forwarded.
  fbdr_update #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS),
    .AW      (AW)
  ) u_update (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_row_index    (in_row_index),
    .in_column_index (in_column_index),
    .in_pixel_word   (in_pixel_word),
    .enabled         (drawing_enabled_r),
    .clr_busy        (clr_busy),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rec_push        (rec_push),
    .rec_data        (rec_data),
    .rec_ready       (rec_ready)
  );

  // Turn each changed word into its command and data bytes.
  fbdr_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .rec_push        (rec_push),
    .rec_data        (rec_data),
    .rec_ready       (rec_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_data     (out_is_data),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

@@ hdl/fbdr_shadow_mem.sv @@
module fbdr_shadow_mem #(
  parameter int DEPTH = fbdr_pkg::ROWS_DEFAULT * fbdr_pkg::COLUMNS_DEFAULT,
  parameter int AW    = 9
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [fbdr_pkg::WORD_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [fbdr_pkg::WORD_W-1:0] wr_data,
  output logic                        clr_busy
);

  logic [fbdr_pkg::WORD_W-1:0] mem [DEPTH];
  logic [fbdr_pkg::WORD_W-1:0] rd_data_r;
  logic [AW-1:0]               clr_addr_r;
  logic                        clr_busy_r;

  // After reset every entry is swept to zero, one per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

@@ hdl/fbdr_update.sv @@
module fbdr_update #(
  parameter int ROWS    = fbdr_pkg::ROWS_DEFAULT,
  parameter int COLUMNS = fbdr_pkg::COLUMNS_DEFAULT,
  parameter int AW      = 9
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fbdr_pkg::ROW_W-1:0]  in_row_index,
  input  logic [fbdr_pkg::COL_W-1:0]  in_column_index,
  input  logic [fbdr_pkg::WORD_W-1:0] in_pixel_word,
  input  logic                        enabled,
  input  logic                        clr_busy,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [fbdr_pkg::WORD_W-1:0] rd_data,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [fbdr_pkg::WORD_W-1:0] wr_data,
  output logic                        rec_push,
  output fbdr_pkg::rec_t              rec_data,
  input  logic                        rec_ready
);

  logic [fbdr_pkg::FULL_ADDR_W-1:0] full_addr;
  logic                             pos_ok;

  logic                        s1_valid_r;
  logic                        s1_ok_r;
  logic [fbdr_pkg::ROW_W-1:0]  s1_row_r;
  logic [fbdr_pkg::COL_W-1:0]  s1_col_r;
  logic [fbdr_pkg::WORD_W-1:0] s1_word_r;
  logic [AW-1:0]               s1_addr_r;

  logic                        fwd_valid_r;
  logic [AW-1:0]               fwd_addr_r;
  logic [fbdr_pkg::WORD_W-1:0] fwd_data_r;

  logic                         run_open_r;
  logic [fbdr_pkg::ROW_W-1:0]   run_row_r;
  logic [fbdr_pkg::COL_W:0]     run_col_r;

  logic [fbdr_pkg::WORD_W-1:0] old_word;
  logic                        changed;
  logic                        cont;
  logic                        s1_go;
  logic                        accept;
  logic [fbdr_pkg::COL_W:0]    next_col;
  logic                        has_next;

  assign full_addr = fbdr_pkg::FULL_ADDR_W'(in_row_index) *
                     fbdr_pkg::FULL_ADDR_W'(COLUMNS) +
                     fbdr_pkg::FULL_ADDR_W'(in_column_index);
  assign pos_ok = (7'(in_row_index) < 7'(ROWS)) && (6'(in_column_index) < 6'(COLUMNS));

  // The entry may have been written at the very edge it was read; the last
  // write is kept aside and wins on an address match.
  assign old_word = (fwd_valid_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : rd_data;
  assign changed  = s1_ok_r && (old_word != s1_word_r);
  assign cont     = run_open_r && (run_row_r == s1_row_r) &&
                    (run_col_r == {1'b0, s1_col_r});
  assign s1_go    = s1_valid_r && (!changed || rec_ready);
  assign in_ready = !clr_busy && (!s1_valid_r || s1_go);
  assign accept   = in_valid && in_ready;
  assign next_col = {1'b0, s1_col_r} + 5'd1;
  assign has_next = 6'(next_col) < 6'(COLUMNS);

  assign rd_en   = accept;
  assign rd_addr = full_addr[AW-1:0];
  assign wr_en   = s1_go && changed;
  assign wr_addr = s1_addr_r;
  assign wr_data = s1_word_r;

  assign rec_push      = wr_en;
  assign rec_data.row  = s1_row_r;
  assign rec_data.col  = s1_col_r;
  assign rec_data.word = s1_word_r;
  assign rec_data.cont = cont;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      run_open_r  <= 1'b0;
      run_row_r   <= '0;
      run_col_r   <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (wr_en) begin
        fwd_valid_r <= 1'b1;
      end
      if (s1_go && s1_ok_r) begin
        if (!changed) begin
          run_open_r <= 1'b0;
        end else begin
          run_open_r <= has_next;
          run_row_r  <= s1_row_r;
          run_col_r  <= next_col;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok_r   <= enabled && pos_ok;
      s1_row_r  <= in_row_index;
      s1_col_r  <= in_column_index;
      s1_word_r <= in_pixel_word;
      s1_addr_r <= full_addr[AW-1:0];
    end
    if (wr_en) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= s1_word_r;
    end
  end

endmodule

@@ hdl/fbdr_emit.sv @@
module fbdr_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rec_push,
  input  fbdr_pkg::rec_t              rec_data,
  output logic                        rec_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_is_data,
  output logic [fbdr_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last_of_run
);

  logic                rec_valid_r;
  fbdr_pkg::rec_t      rec_r;
  fbdr_pkg::byte_sel_t seq_r;
  fbdr_pkg::byte_sel_t seq_nxt;

  logic                        out_valid_r;
  logic                        out_is_data_r;
  logic [fbdr_pkg::BYTE_W-1:0] out_byte_r;
  logic                        out_last_r;

  logic                        out_load;
  logic                        rec_done;
  logic                        byte_is_data;
  logic [fbdr_pkg::BYTE_W-1:0] byte_val;

  assign out_load  = rec_valid_r && (!out_valid_r || out_ready);
  assign rec_done  = out_load && (seq_r == fbdr_pkg::BYTE_LO);
  assign rec_ready = !rec_valid_r || rec_done;

  always_comb begin
    unique case (seq_r)
      fbdr_pkg::BYTE_ROW: begin
        byte_is_data = 1'b0;
        byte_val     = fbdr_pkg::ADDR_CMD | fbdr_pkg::BYTE_W'(rec_r.row);
        seq_nxt      = fbdr_pkg::BYTE_COL;
      end
      fbdr_pkg::BYTE_COL: begin
        byte_is_data = 1'b0;
        byte_val     = fbdr_pkg::ADDR_CMD | fbdr_pkg::BYTE_W'(rec_r.col);
        seq_nxt      = fbdr_pkg::BYTE_HI;
      end
      fbdr_pkg::BYTE_HI: begin
        byte_is_data = 1'b1;
        byte_val     = rec_r.word[fbdr_pkg::WORD_W-1:fbdr_pkg::BYTE_W];
        seq_nxt      = fbdr_pkg::BYTE_LO;
      end
      fbdr_pkg::BYTE_LO: begin
        byte_is_data = 1'b1;
        byte_val     = rec_r.word[fbdr_pkg::BYTE_W-1:0];
        seq_nxt      = fbdr_pkg::BYTE_ROW;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_valid_r <= 1'b0;
      seq_r       <= fbdr_pkg::BYTE_ROW;
      out_valid_r <= 1'b0;
    end else begin
      if (rec_push) begin
        rec_valid_r <= 1'b1;
        seq_r       <= rec_data.cont ? fbdr_pkg::BYTE_HI : fbdr_pkg::BYTE_ROW;
      end else if (rec_done) begin
        rec_valid_r <= 1'b0;
      end else if (out_load) begin
        seq_r <= seq_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_push) begin
      rec_r <= rec_data;
    end
    if (out_load) begin
      out_is_data_r <= byte_is_data;
      out_byte_r    <= byte_val;
      out_last_r    <= (seq_r == fbdr_pkg::BYTE_LO);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_data     = out_is_data_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule

@@ hdl/fbdr_checker.sv @@
`include "assert_macros.svh"

module fbdr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_is_data,
  input logic [fbdr_pkg::BYTE_W-1:0] out_byte,
  input logic                        out_last_of_run
);

  logic                        out_take;
  logic                        out_stall;
  logic                        out_take_hi;
  logic [fbdr_pkg::BYTE_W+1:0] out_payload;

  assign out_take    = out_valid && out_ready;
  assign out_stall   = out_valid && !out_ready;
  assign out_take_hi = out_take && out_is_data && !out_last_of_run;
  assign out_payload = {out_is_data, out_byte, out_last_of_run};

  // A stalled byte is held as it is.
  `FBDR_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_payload), "stalled byte changed")

  // Reset empties the output and starts the shadow sweep.
  `FBDR_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid, "output valid after reset")
  `FBDR_ASSERT_ALWAYS(a_rst_in, !rst_n |=> !in_ready, "input ready during shadow sweep")

  // The bytes of one request follow each other without gaps.
  `FBDR_ASSERT(a_run_gapless, out_take && !out_last_of_run |=> out_valid, "gap inside a request")

  // The high data byte is always followed directly by the low one.
  `FBDR_ASSERT(a_hi_then_lo, out_take_hi |=> out_is_data && out_last_of_run, "low byte missing")

endmodule

bind framebuffer_diff_refresh fbdr_checker u_fbdr_checker (.*);

@@ bench/framebuffer_diff_refresh_tb.sv @@
// One byte the panel is expected to receive.
typedef struct {
  logic                        is_data;
  logic [fbdr_pkg::BYTE_W-1:0] data_byte;
  logic                        last;
} panel_byte_t;

// Mirror of the panel contents and the open run. It turns each accepted
// request into the bytes it should cause and checks the bytes that come out.
class panel_mirror;
  logic [fbdr_pkg::WORD_W-1:0] shadow [fbdr_pkg::ROWS_DEFAULT * fbdr_pkg::COLUMNS_DEFAULT];
  bit                          run_open;
  logic [fbdr_pkg::ROW_W-1:0]  run_row;
  logic [fbdr_pkg::ROW_W-1:0]  run_next_col;
  bit                          drawing;
  panel_byte_t                 awaited_bytes[$];
  int                          failures;

  function new();
    foreach (shadow[i]) shadow[i] = '0;
    run_open     = 1'b0;
    run_row      = '0;
    run_next_col = '0;
    drawing      = 1'b0;
    failures     = 0;
  endfunction

  function logic [fbdr_pkg::WORD_W-1:0] shadow_word(input logic [fbdr_pkg::ROW_W-1:0] row,
                                                     input logic [fbdr_pkg::COL_W-1:0] col);
    return shadow[int'(row) * fbdr_pkg::COLUMNS_DEFAULT + int'(col)];
  endfunction

  function void queue_byte(input logic is_data, input logic [7:0] data_byte, input logic last);
    panel_byte_t b;
    b.is_data   = is_data;
    b.data_byte = data_byte;
    b.last      = last;
    awaited_bytes.push_back(b);
  endfunction

  function void note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("MISMATCH %0d: %s", failures, msg);
  endfunction

  // Called once per accepted request.
  function void log_request(input logic [fbdr_pkg::ROW_W-1:0]  row,
                            input logic [fbdr_pkg::COL_W-1:0]  col,
                            input logic [fbdr_pkg::WORD_W-1:0] word);
    int slot;
    bit continues;
    if (!drawing) return;
    if (int'(row) >= fbdr_pkg::ROWS_DEFAULT || int'(col) >= fbdr_pkg::COLUMNS_DEFAULT) return;
    slot = int'(row) * fbdr_pkg::COLUMNS_DEFAULT + int'(col);
    if (shadow[slot] == word) begin
      run_open = 1'b0;
      return;
    end
    shadow[slot] = word;
    continues = run_open && run_row == row && run_next_col == 5'(col);
    if (!continues) begin
      queue_byte(1'b0, fbdr_pkg::ADDR_CMD | 8'(row), 1'b0);
      queue_byte(1'b0, fbdr_pkg::ADDR_CMD | 8'(col), 1'b0);
    end
    queue_byte(1'b1, word[15:8], 1'b0);
    queue_byte(1'b1, word[7:0], 1'b1);
    if (int'(col) + 1 < fbdr_pkg::COLUMNS_DEFAULT) begin
      run_open     = 1'b1;
      run_row      = row;
      run_next_col = 5'(int'(col) + 1);
    end else begin
      run_open = 1'b0;
    end
  endfunction

  // Called once per accepted result byte.
  function void check_byte(input logic is_data, input logic [7:0] data_byte, input logic last);
    panel_byte_t want;
    if (awaited_bytes.size() == 0) begin
      note_failure($sformatf("unexpected byte is_data=%0b byte=%02h last=%0b",
                             is_data, data_byte, last));
      return;
    end
    want = awaited_bytes.pop_front();
    if (want.is_data !== is_data || want.data_byte !== data_byte || want.last !== last)
      note_failure($sformatf({"expected is_data=%0b byte=%02h last=%0b, ",
                              "got is_data=%0b byte=%02h last=%0b"},
                             want.is_data, want.data_byte, want.last, is_data, data_byte, last));
  endfunction
endclass

module framebuffer_diff_refresh_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_MAX         = fbdr_pkg::ROWS_DEFAULT - 1;
  localparam int COL_MAX         = fbdr_pkg::COLUMNS_DEFAULT - 1;
  localparam int RANDOM_REQUESTS = 240;
  localparam int MAX_IDLE        = 17;
  // An unchanged or ignored word needs no output bytes to leave the pipeline, so this
  // is ample room for such a word to leave it before a register write.
  localparam int SETTLE_CYCLES   = 16;
  localparam bit DRAW_OFF        = 1'b0;
  localparam bit DRAW_ON         = 1'b1;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [fbdr_pkg::ROW_W-1:0]  in_row_index = '0;
  logic [fbdr_pkg::COL_W-1:0]  in_column_index = '0;
  logic [fbdr_pkg::WORD_W-1:0] in_pixel_word = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        out_is_data;
  logic [fbdr_pkg::BYTE_W-1:0] out_byte;
  logic                        out_last_of_run;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic                        cfg_drawing_enabled = 1'b0;

  panel_mirror mirror;
  // While set, neither side inserts idle cycles.
  bit          quiet = 1'b0;
  // Requests accepted while drawing was enabled.
  int          requests_sent = 0;

  always #5 clk = ~clk;

  framebuffer_diff_refresh dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_row_index        (in_row_index),
    .in_column_index     (in_column_index),
    .in_pixel_word       (in_pixel_word),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_is_data         (out_is_data),
    .out_byte            (out_byte),
    .out_last_of_run     (out_last_of_run),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_drawing_enabled (cfg_drawing_enabled)
  );

  // Offers one request after a random gap and waits until the block takes it.
  // Valid stays high after acceptance, so a zero gap gives back-to-back requests.
  task automatic send_word(input logic [fbdr_pkg::ROW_W-1:0]  row,
                           input logic [fbdr_pkg::COL_W-1:0]  col,
                           input logic [fbdr_pkg::WORD_W-1:0] word);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_row_index    <= row;
    in_column_index <= col;
    in_pixel_word   <= word;
    do @(posedge clk); while (!in_ready);
    if (mirror.drawing) requests_sent++;
    mirror.log_request(row, col, word);
  endtask

  // Stops offering requests and waits until every expected byte has come out.
  // With settle set, it also lets a trailing ignored word clear the pipeline.
  task automatic drain_results(input bit settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (mirror.awaited_bytes.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The register is only written while the block is idle.
  task automatic write_drawing(input bit enable);
    drain_results(1'b1);
    cfg_valid           <= 1'b1;
    cfg_drawing_enabled <= enable;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mirror.drawing = enable;
  endtask

  // A run of neighboring columns in one row. Now and then a word repeats what
  // the panel already shows, which closes the run in the middle.
  task automatic send_run();
    logic [fbdr_pkg::ROW_W-1:0]  row;
    logic [fbdr_pkg::WORD_W-1:0] word;
    int col;
    int len;
    row = $urandom_range(0, ROW_MAX);
    col = $urandom_range(0, COL_MAX);
    len = $urandom_range(1, 6);
    repeat (len) begin
      if (col > COL_MAX) break;
      case ($urandom_range(0, 9))
        0:       word = mirror.shadow_word(row, col[3:0]);
        1:       word = '1;
        2:       word = '0;
        default: word = 16'($urandom);
      endcase
      send_word(row, col[3:0], word);
      col++;
    end
  endtask

  // Result side: a random stall before each byte, then ready until one is taken.
  initial begin : result_sink
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Every byte accepted on the result channel is checked against the mirror.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      mirror.check_byte(out_is_data, out_byte, out_last_of_run);
  end

  initial begin : stimulus
    logic [fbdr_pkg::ROW_W-1:0] r;
    logic [fbdr_pkg::COL_W-1:0] c;
    int  done;
    bit  paused;
    bit  off_phase;

    mirror    = new();
    paused    = 1'b0;
    off_phase = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Drawing off: these requests are offered while the shadow sweep is still
    // running, are taken once it ends, and must cause nothing and leave the
    // shadow untouched.
    write_drawing(DRAW_OFF);
    send_word(5'd0, 4'd0, 16'hFFFF);
    send_word(5'd31, 4'd15, 16'h1234);
    send_word(5'd12, 4'd7, 16'hA5A5);

    write_drawing(DRAW_ON);
    // Zero matches the cleared shadow, so nothing is sent.
    send_word(5'd0, 4'd0, 16'h0000);
    // A fresh run with both address commands, then its continuation.
    send_word(5'd0, 4'd0, 16'hFFFF);
    send_word(5'd0, 4'd1, 16'h8001);
    // An unchanged word closes the run, so the next column needs addresses again.
    send_word(5'd0, 4'd2, 16'h0000);
    send_word(5'd0, 4'd3, 16'h00FF);
    // Last column: the run ends there and does not wrap into column zero.
    send_word(5'd31, 4'd14, 16'hAAAA);
    send_word(5'd31, 4'd15, 16'h5555);
    send_word(5'd31, 4'd0, 16'h1234);
    send_word(5'd31, 4'd1, 16'hFFFF);
    // Right column in another row, then the right row with a skipped column.
    send_word(5'd17, 4'd2, 16'h0F0F);
    send_word(5'd17, 4'd4, 16'hF0F0);
    send_word(5'd17, 4'd4, 16'hF0F0);
    send_word(5'd17, 4'd5, 16'h0001);
    // Repeat of an old value, then a change back to zero.
    send_word(5'd0, 4'd0, 16'hFFFF);
    send_word(5'd0, 4'd0, 16'h0000);
    // A run left open across a disabled phase survives it, since ignored
    // requests change nothing.
    send_word(5'd5, 4'd7, 16'h1111);
    write_drawing(DRAW_OFF);
    send_word(5'd5, 4'd8, 16'h2222);
    write_drawing(DRAW_ON);
    send_word(5'd5, 4'd8, 16'h2222);

    done = 0;
    requests_sent = 0;
    while (requests_sent < RANDOM_REQUESTS) begin
      done = requests_sent;
      // Hold the sender until every expected byte has come out.
      if (!paused && done >= 90) begin
        paused = 1'b1;
        drain_results(1'b0);
      end
      // A phase with drawing off in the middle of the random traffic.
      if (!off_phase && done >= 150) begin
        off_phase = 1'b1;
        write_drawing(DRAW_OFF);
        repeat (8) send_word(5'($urandom), 4'($urandom), 16'($urandom));
        write_drawing(DRAW_ON);
      end
      quiet = (done >= 200 && done < 240);

      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: send_run();
        6, 7: send_word(5'($urandom), 4'($urandom), 16'($urandom));
        8: begin
          r = 5'($urandom);
          c = 4'($urandom);
          send_word(r, c, mirror.shadow_word(r, c));
        end
        default: begin
          // Two changes at one position: the second never continues the run.
          r = 5'($urandom);
          c = 4'($urandom);
          send_word(r, c, 16'($urandom));
          send_word(r, c, 16'($urandom));
        end
      endcase
    end
    quiet = 1'b0;

    // Wait for the last bytes, then give the block time to show any extra ones.
    drain_results(1'b1);
    if (mirror.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Covers the shadow sweep after reset and the slowest legal run many times over.
  initial begin : watchdog
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
